>>> hdl/llcc_pkg.sv
`default_nettype none

package llcc_pkg;

  // pixel and result field widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned CENTER_W = 19;

  // configuration port
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_FIRST_COL = 2'd1,
    CFG_END_COL   = 2'd2
  } cfg_idx_t;

  localparam logic [CHAN_W-1:0] THRESHOLD_RST = 8'd50;
  localparam logic [CFG_W-1:0]  FIRST_COL_RST = 13'd0;
  localparam logic [CFG_W-1:0]  END_COL_RST   = 13'd4096;

  // column geometry
  localparam int unsigned MAX_ROWS = 2048;
  localparam int unsigned ROWC_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNT_W    = ROWC_W;
  localparam int unsigned SUM_W    = $clog2(MAX_ROWS * (MAX_ROWS - 1) / 2 + 1);
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned DVD_W    = SUM_W + FRAC_W;
  localparam int unsigned STEP_W   = $clog2(DVD_W);

  // BGR to gray, 14-bit fixed point with rounding
  localparam int unsigned WSUM_W     = 22;
  localparam int unsigned GRAY_SHIFT = 14;
  localparam logic [WSUM_W-1:0] W_BLUE    = 22'd1868;
  localparam logic [WSUM_W-1:0] W_GREEN   = 22'd9617;
  localparam logic [WSUM_W-1:0] W_RED     = 22'd4899;
  localparam logic [WSUM_W-1:0] GRAY_HALF = 22'd8192;

  // front to back queue, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [COL_W-1:0]  column;
    logic              column_end;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0]    out_column;
    logic [CENTER_W-1:0] center_row;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] row_sum;
  } job_t;

endpackage

`default_nettype wire

>>> hdl/llcc_front.sv
`default_nettype none

module llcc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire llcc_pkg::pixel_t              in_data,
  input  wire logic                          cfg_we,
  input  wire logic [llcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [llcc_pkg::CFG_W-1:0]    cfg_data,
  output logic                               q_push,
  output llcc_pkg::job_t                     q_job,
  input  wire logic                          q_full
);

  logic [llcc_pkg::CHAN_W-1:0] thr_r;
  logic [llcc_pkg::CFG_W-1:0]  first_col_r;
  logic [llcc_pkg::CFG_W-1:0]  end_col_r;

  logic                         s1_valid_r;
  logic [llcc_pkg::WSUM_W-1:0]  s1_wsum_r;
  logic [llcc_pkg::COL_W-1:0]   s1_col_r;
  logic                         s1_last_r;

  logic [llcc_pkg::ROWC_W-1:0]  row_cnt_r;
  logic [llcc_pkg::CNT_W-1:0]   cnt_r;
  logic [llcc_pkg::SUM_W-1:0]   sum_r;

  logic [llcc_pkg::WSUM_W-1:0]  wsum;
  logic [llcc_pkg::CHAN_W-1:0]  gray;
  logic                         row_active;
  logic                         bright;
  logic [llcc_pkg::CNT_W-1:0]   cnt_nxt;
  logic [llcc_pkg::SUM_W-1:0]   sum_nxt;
  logic [llcc_pkg::CFG_W-1:0]   col_ext;
  logic                         in_range;
  logic                         s1_fire;
  logic                         in_fire;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= llcc_pkg::THRESHOLD_RST;
      first_col_r <= llcc_pkg::FIRST_COL_RST;
      end_col_r   <= llcc_pkg::END_COL_RST;
    end else if (cfg_we) begin
      unique case (llcc_pkg::cfg_idx_t'(cfg_index))
        llcc_pkg::CFG_THRESHOLD: thr_r       <= cfg_data[llcc_pkg::CHAN_W-1:0];
        llcc_pkg::CFG_FIRST_COL: first_col_r <= cfg_data;
        llcc_pkg::CFG_END_COL:   end_col_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: weighted channel sum, rounding offset included
  assign wsum = llcc_pkg::W_BLUE  * llcc_pkg::WSUM_W'(in_data.blue)
              + llcc_pkg::W_GREEN * llcc_pkg::WSUM_W'(in_data.green)
              + llcc_pkg::W_RED   * llcc_pkg::WSUM_W'(in_data.red)
              + llcc_pkg::GRAY_HALF;

  // a column end waits in stage 1 until the queue has room
  assign s1_fire  = s1_valid_r && !(s1_last_r && q_full);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_wsum_r <= wsum;
      s1_col_r  <= in_data.column;
      s1_last_r <= in_data.column_end;
    end
  end

  // stage 2: threshold and accumulate
  assign gray       = s1_wsum_r[llcc_pkg::GRAY_SHIFT +: llcc_pkg::CHAN_W];
  assign row_active = row_cnt_r < llcc_pkg::ROWC_W'(llcc_pkg::MAX_ROWS);
  assign bright     = row_active && (gray > thr_r);
  assign cnt_nxt    = cnt_r + llcc_pkg::CNT_W'(bright);
  assign sum_nxt    = bright ? sum_r + llcc_pkg::SUM_W'(row_cnt_r) : sum_r;

  assign col_ext  = llcc_pkg::CFG_W'(s1_col_r);
  assign in_range = (col_ext >= first_col_r) && (col_ext < end_col_r);

  assign q_push        = s1_fire && s1_last_r && in_range && (cnt_nxt != '0);
  assign q_job.column  = s1_col_r;
  assign q_job.count   = cnt_nxt;
  assign q_job.row_sum = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        row_cnt_r <= '0;
        cnt_r     <= '0;
        sum_r     <= '0;
      end else begin
        row_cnt_r <= row_active ? row_cnt_r + 1'b1 : row_cnt_r;
        cnt_r     <= cnt_nxt;
        sum_r     <= sum_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_rows_capped: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= llcc_pkg::ROWC_W'(llcc_pkg::MAX_ROWS))
    else $error("row counter past MAX_ROWS");

  a_count_le_rows: assert property (@(posedge clk) disable iff (!rst_n)
    llcc_pkg::ROWC_W'(cnt_r) <= row_cnt_r)
    else $error("bright count above rows seen");

  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> row_cnt_r == '0 && cnt_r == '0 && sum_r == '0)
    else $error("accumulators not cleared after column end");
`endif

endmodule

`default_nettype wire

>>> hdl/llcc_queue.sv
`default_nettype none

module llcc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire llcc_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output llcc_pkg::job_t      pop_job,
  output logic                empty
);

  llcc_pkg::job_t              entries_r [llcc_pkg::QUEUE_DEPTH];
  logic [llcc_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [llcc_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [llcc_pkg::QCNT_W-1:0] count_r;

  assign full    = count_r == llcc_pkg::QCNT_W'(llcc_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign pop_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= llcc_pkg::QCNT_W'(llcc_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> hdl/llcc_back.sv
`default_nettype none

module llcc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire llcc_pkg::job_t q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output llcc_pkg::result_t   out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                           state_r;
  logic [llcc_pkg::DVD_W-1:0]       dvd_r;
  logic [llcc_pkg::CNT_W-1:0]       div_r;
  logic [llcc_pkg::CNT_W-1:0]       rem_r;
  logic [llcc_pkg::STEP_W-1:0]      step_r;
  logic [llcc_pkg::COL_W-1:0]       col_r;

  logic                             out_valid_r;
  llcc_pkg::result_t                out_data_r;

  logic [llcc_pkg::CNT_W:0]         trial;
  logic [llcc_pkg::CNT_W-1:0]       diff;
  logic                             ge;
  logic                             last_step;
  logic                             out_free;

  // restoring division, one quotient bit per cycle; quotient shifts into dvd_r
  assign trial     = {rem_r, dvd_r[llcc_pkg::DVD_W-1]};
  assign ge        = trial >= {1'b0, div_r};
  assign diff      = trial[llcc_pkg::CNT_W-1:0] - div_r;
  assign last_step = step_r == llcc_pkg::STEP_W'(llcc_pkg::DVD_W - 1);
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: if (!q_empty) state_r <= ST_DIV;
        ST_DIV:  if (last_step) state_r <= ST_DONE;
        ST_DONE: if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd_r  <= {q_job.row_sum, {llcc_pkg::FRAC_W{1'b0}}};
      div_r  <= q_job.count;
      rem_r  <= '0;
      step_r <= '0;
      col_r  <= q_job.column;
    end else if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[llcc_pkg::DVD_W-2:0], ge};
      rem_r  <= ge ? diff : trial[llcc_pkg::CNT_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  // output register: next division runs while a result waits here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.out_column <= col_r;
      out_data_r.center_row <= dvd_r[llcc_pkg::CENTER_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < div_r)
    else $error("division remainder not below divisor");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && !last_step |=> state_r == ST_DIV && step_r == $past(step_r) + 1'b1)
    else $error("division step lost");
`endif

endmodule

`default_nettype wire

>>> hdl/laser_line_column_centroid.sv
// Laser stripe centre per image column (gray gravity centre).
// Input channel in_valid/in_ready/in_data: one pixel a beat, columns streamed
// top row first, column_end set on the bottom pixel. Pixels are taken at one
// per cycle while in_ready is high; only rows below MAX_ROWS of a column count.
// Result channel out_valid/out_ready/out_data: one beat per column that lies in
// [first_column, end_column) and holds a pixel whose gray exceeds the threshold;
// center_row is the mean bright row with 8 fraction bits, truncated.
// Config: cfg_we writes cfg_data into register cfg_index (0 threshold,
// 1 first column, 2 end column); write only while the block is idle.
// A column_end beat's result passes through stage 1, the queue, the divider and
// the output register. The shared bit-serial divider works on one column at a
// time; a two-entry queue holds finished columns ahead of it, so when the queue
// is full a column end stalls in_ready.
// Reset (synchronous, rst_n low) restores register defaults and drops any
// partial column, queued column and pending result.
// When the receiver stalls, the result waits in the output register, the next
// division still runs, then the queue fills and in_ready drops on a column end.
`default_nettype none

module laser_line_column_centroid (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire llcc_pkg::pixel_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output llcc_pkg::result_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [llcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [llcc_pkg::CFG_W-1:0]     cfg_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  llcc_pkg::job_t push_job;
  llcc_pkg::job_t pop_job;

  llcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_full    (q_full)
  );

  llcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  llcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sim/laser_line_column_centroid_test.sv
`default_nettype none

module laser_line_column_centroid_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMN_ROWS  = llcc_pkg::MAX_ROWS;
  localparam int unsigned PIPE_LATENCY = llcc_pkg::DVD_W + 4;
  localparam int unsigned DRAIN_CYCLES = 4 * PIPE_LATENCY;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [llcc_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  class centroid_scoreboard;
    logic [llcc_pkg::CHAN_W-1:0] threshold;
    logic [llcc_pkg::CFG_W-1:0]  first_col;
    logic [llcc_pkg::CFG_W-1:0]  end_col;
    int unsigned                 row_idx;
    int unsigned                 bright_cnt;
    longint unsigned             row_total;
    llcc_pkg::result_t           expected_centers[$];
    int unsigned                 errors;

    function new();
      threshold  = llcc_pkg::THRESHOLD_RST;
      first_col  = llcc_pkg::FIRST_COL_RST;
      end_col    = llcc_pkg::END_COL_RST;
      row_idx    = 0;
      bright_cnt = 0;
      row_total  = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [llcc_pkg::CFG_IDX_W-1:0] idx,
                            logic [llcc_pkg::CFG_W-1:0] val);
      unique case (idx)
        llcc_pkg::CFG_THRESHOLD: threshold = val[llcc_pkg::CHAN_W-1:0];
        llcc_pkg::CFG_FIRST_COL: first_col = val;
        llcc_pkg::CFG_END_COL:   end_col = val;
        default: ;
      endcase
    endfunction

    // BGR weights in 14-bit fixed point, rounded
    function int unsigned gray_of(llcc_pkg::pixel_t px);
      return (1868 * int'(px.blue) + 9617 * int'(px.green) + 4899 * int'(px.red)
              + 8192) >> 14;
    endfunction

    function void note_pixel(llcc_pkg::pixel_t px);
      llcc_pkg::result_t r;
      if (row_idx < COLUMN_ROWS) begin
        if (gray_of(px) > threshold) begin
          bright_cnt++;
          row_total += row_idx;
        end
        row_idx++;
      end
      if (px.column_end) begin
        if ({1'b0, px.column} >= first_col && {1'b0, px.column} < end_col &&
            bright_cnt != 0) begin
          r.out_column = px.column;
          r.center_row = llcc_pkg::CENTER_W'((row_total << llcc_pkg::FRAC_W) / bright_cnt);
          expected_centers = {expected_centers, r};
        end
        row_idx    = 0;
        bright_cnt = 0;
        row_total  = 0;
      end
    endfunction

    function void check_result(llcc_pkg::result_t got);
      llcc_pkg::result_t want;
      if (expected_centers.size() == 0) begin
        $error("unexpected result beat: out_column %0d center_row %0d",
               got.out_column, got.center_row);
        errors++;
        return;
      end
      want = expected_centers.pop_front();
      if (got.out_column !== want.out_column) begin
        $error("out_column: expected %0d, actual %0d", want.out_column, got.out_column);
        errors++;
      end
      if (got.center_row !== want.center_row) begin
        $error("center_row: expected %0d, actual %0d", want.center_row, got.center_row);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_centers.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  llcc_pkg::pixel_t               in_data;
  logic                           out_valid;
  logic                           out_ready;
  llcc_pkg::result_t              out_data;
  logic                           cfg_we;
  logic [llcc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [llcc_pkg::CFG_W-1:0]     cfg_data;

  centroid_scoreboard sb = new();
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned cycle_count = 0;

  laser_line_column_centroid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(rx_idle_en && $urandom_range(99) < 8);
      end
    end
  end

  function automatic llcc_pkg::pixel_t make_px(int unsigned b, int unsigned g,
                                               int unsigned r, int unsigned col, bit last);
    llcc_pkg::pixel_t px;
    px.blue       = llcc_pkg::CHAN_W'(b);
    px.green      = llcc_pkg::CHAN_W'(g);
    px.red        = llcc_pkg::CHAN_W'(r);
    px.column     = llcc_pkg::COL_W'(col);
    px.column_end = last;
    return px;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_pixel(input llcc_pkg::pixel_t px);
    if (tx_idle_en && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [llcc_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = llcc_pkg::CFG_W'(val);
    sb.write_reg(idx, llcc_pkg::CFG_W'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // columns without a result may still be in flight after the last beat
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic llcc_pkg::pixel_t random_pixel();
    int unsigned v;
    unique case ($urandom_range(2))
      0: return make_px($urandom_range(255), $urandom_range(255), $urandom_range(255), 0, 0);
      1: begin
        // equal channels give gray equal to the channel value
        v = sb.threshold + $urandom_range(2);
        v = (v == 0) ? 0 : v - 1;
        if (v > 255) v = 255;
        return make_px(v, v, v, 0, 0);
      end
      default: return make_px($urandom_range(40), $urandom_range(40), $urandom_range(40), 0, 0);
    endcase
  endfunction

  function automatic int unsigned pick_column();
    unique case ($urandom_range(5))
      0: return (sb.first_col - 1) & 12'hfff;
      1: return sb.first_col & 12'hfff;
      2: return (sb.end_col - 1) & 12'hfff;
      3: return sb.end_col & 12'hfff;
      default: return $urandom_range(4095);
    endcase
  endfunction

  task automatic run_columns(input int unsigned n_items);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      pick;
    int unsigned      col;
    llcc_pkg::pixel_t px;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 60);
      else len = $urandom_range(61, 200);
      col = pick_column();
      for (int r = 0; r < len; r++) begin
        px = random_pixel();
        // only the index on the last beat of a column matters
        px.column     = ($urandom_range(9) == 0) ? llcc_pkg::COL_W'($urandom)
                                                 : llcc_pkg::COL_W'(col);
        px.column_end = (r == len - 1);
        send_pixel(px);
      end
      sent += len;
    end
  endtask

  task automatic run_phase(input int unsigned thr, input int unsigned first_c,
                           input int unsigned end_c, input int unsigned n_items);
    wait_idle();
    write_reg(llcc_pkg::CFG_THRESHOLD, thr);
    write_reg(llcc_pkg::CFG_FIRST_COL, first_c);
    write_reg(llcc_pkg::CFG_END_COL, end_c);
    run_columns(n_items);
  endtask

  initial begin
    int unsigned lo;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = llcc_pkg::CFG_THRESHOLD;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed columns with the reset settings
    send_pixel(make_px(255, 255, 255, 0, 1));
    send_pixel(make_px(0, 0, 0, 4095, 1));
    send_pixel(make_px(255, 255, 255, 17, 0));
    send_pixel(make_px(0, 0, 0, 17, 0));
    send_pixel(make_px(255, 255, 255, 4095, 1));
    // gray exactly at the threshold is not bright
    send_pixel(make_px(50, 50, 50, 2048, 0));
    send_pixel(make_px(51, 51, 51, 2048, 1));
    send_pixel(make_px(255, 0, 0, 1, 0));
    send_pixel(make_px(0, 255, 0, 1, 0));
    send_pixel(make_px(0, 0, 255, 1, 1));
    // rows past the column height are ignored
    for (int r = 0; r < COLUMN_ROWS + 2; r++)
      send_pixel(make_px(255, 255, 255, 4094, r == COLUMN_ROWS + 1));
    send_pixel(make_px(255, 255, 255, 5, 1));

    // no idling anywhere in this phase
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(0, 0, 4096, 60);
    wait_idle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    run_phase(50, 0, 4096, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++)
      send_pixel(make_px(255, 255, 255, $urandom_range(4095), 1));
    run_columns(60);

    run_phase(255, 0, 4096, 50);
    run_phase($urandom_range(255), 4096, 4096, 40);
    run_phase($urandom_range(255), 0, 0, 40);
    run_phase($urandom_range(255), 3000, 100, 40);

    wait_idle();
    write_reg(CFG_SPARE_IDX, $urandom_range(8191));
    run_columns(60);

    for (int p = 0; p < 3; p++) begin
      lo = $urandom_range(4095);
      run_phase($urandom_range(20, 200), lo, $urandom_range(lo + 1, 4096), 60);
    end
    run_phase($urandom_range(255), $urandom_range(2000), $urandom_range(4096, 8191), 60);

    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/llcc_pkg.sv
hdl/llcc_front.sv
hdl/llcc_queue.sv
hdl/llcc_back.sv
hdl/laser_line_column_centroid.sv
sim/laser_line_column_centroid_test.sv
